// ===== rtl/brbc_pkg.sv =====
// Package for the bracket range balance checker.
// Holds the field widths, symbol codes, request kinds, sequencer states and the symbol encoder.
// No dependencies.
package brbc_pkg;

  // Default store depth
  localparam int MAX_LENGTH_DEF = 1024;

  // Fixed field widths
  localparam int POS_W  = 11;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 4;
  localparam int OPEN_W = 2;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Stored symbol codes
  localparam logic [CODE_W-1:0] CODE_OTHER   = 4'd0;
  localparam logic [CODE_W-1:0] CODE_OPEN_P  = 4'd1;
  localparam logic [CODE_W-1:0] CODE_OPEN_S  = 4'd2;
  localparam logic [CODE_W-1:0] CODE_OPEN_A  = 4'd3;
  localparam logic [CODE_W-1:0] CODE_OPEN_C  = 4'd4;
  localparam logic [CODE_W-1:0] CODE_CLOSE_P = 4'd5;
  localparam logic [CODE_W-1:0] CODE_CLOSE_S = 4'd6;
  localparam logic [CODE_W-1:0] CODE_CLOSE_A = 4'd7;
  localparam logic [CODE_W-1:0] CODE_CLOSE_C = 4'd8;

  // Raw characters
  localparam logic [SYM_W-1:0] CH_OPEN_P  = 8'h28;  // (
  localparam logic [SYM_W-1:0] CH_CLOSE_P = 8'h29;  // )
  localparam logic [SYM_W-1:0] CH_OPEN_S  = 8'h5B;  // [
  localparam logic [SYM_W-1:0] CH_CLOSE_S = 8'h5D;  // ]
  localparam logic [SYM_W-1:0] CH_OPEN_A  = 8'h3C;  // <
  localparam logic [SYM_W-1:0] CH_CLOSE_A = 8'h3E;  // >
  localparam logic [SYM_W-1:0] CH_OPEN_C  = 8'h7B;  // {
  localparam logic [SYM_W-1:0] CH_CLOSE_C = 8'h7D;  // }

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Map a raw character to its stored code
  function automatic logic [CODE_W-1:0] encode_symbol(input logic [SYM_W-1:0] ch);
    logic [CODE_W-1:0] code;
    case (ch)
      CH_OPEN_P:  code = CODE_OPEN_P;
      CH_OPEN_S:  code = CODE_OPEN_S;
      CH_OPEN_A:  code = CODE_OPEN_A;
      CH_OPEN_C:  code = CODE_OPEN_C;
      CH_CLOSE_P: code = CODE_CLOSE_P;
      CH_CLOSE_S: code = CODE_CLOSE_S;
      CH_CLOSE_A: code = CODE_CLOSE_A;
      CH_CLOSE_C: code = CODE_CLOSE_C;
      default:    code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/bracket_range_balance_checker.sv =====
// Bracket range balance checker: symbol store, opener stack and the query sequencer.
// Depends on brbc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): a write request (in_kind = 0) codes
//   in_symbol and stores it at 1-based in_position. Positions of zero or past
//   MAX_LENGTH are dropped. A query request (in_kind = 1) walks the stored
//   range in_range_begin..in_range_end. A begin of zero counts as 1 and an end
//   past MAX_LENGTH counts as MAX_LENGTH.
//   Output channel (out_valid / out_stall): one out_balanced per query and
//   none per write.
//   Flow: a write leaves the sequencer idle, so the next request may follow at
//   once. A query walks its range one position at a time, and each position
//   passes through a read state for the registered store and stack read and
//   an evaluate state for the stack update. The walk stops at the first
//   failing position, and an empty range goes straight to the done state.
//   The done state then hands the result to the output register.
//   in_stall is high from query acceptance until its result is registered.
//   A finished result waits in the output register while out_stall is high.
//   A later query result waits in the done state until that register is
//   free, and the input stays stalled meanwhile.
//   Reset clears the sequencer, the stack fill and out_valid. The store
//   contents are undefined until written.
module bracket_range_balance_checker #(
  parameter int MAX_LENGTH = brbc_pkg::MAX_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [brbc_pkg::POS_W-1:0] in_position,
  input  logic [brbc_pkg::SYM_W-1:0] in_symbol,
  input  logic [brbc_pkg::POS_W-1:0] in_range_begin,
  input  logic [brbc_pkg::POS_W-1:0] in_range_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_balanced
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int FW = $clog2(MAX_LENGTH + 1);
  localparam int CW = (FW > brbc_pkg::POS_W) ? FW : brbc_pkg::POS_W;
  localparam logic [CW-1:0] MAX_POS  = CW'(MAX_LENGTH);
  localparam logic [FW-1:0] MAX_FILL = FW'(MAX_LENGTH);

  // Storage
  logic [brbc_pkg::CODE_W-1:0] store_mem [MAX_LENGTH];
  logic [brbc_pkg::OPEN_W-1:0] stack_mem [MAX_LENGTH];

  // Registers
  brbc_pkg::state_t            state_r, state_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               last_r, last_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;
  logic                        result_r, result_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_balanced_r, out_balanced_nxt;
  logic [brbc_pkg::CODE_W-1:0] code_rd_r;
  logic [brbc_pkg::OPEN_W-1:0] top_rd_r;

  // Memory ports
  logic                        st_we;
  logic [AW-1:0]               st_waddr;
  logic [brbc_pkg::CODE_W-1:0] st_wdata;
  logic                        stk_we;
  logic [AW-1:0]               stk_waddr;
  logic [brbc_pkg::OPEN_W-1:0] stk_wdata;
  logic [AW-1:0]               st_raddr;
  logic [AW-1:0]               stk_raddr;

  // Helpers
  logic          in_accept;
  logic          out_free;
  logic [CW-1:0] wr_pos;
  logic [CW-1:0] wr_pos_m1;
  logic [CW-1:0] q_first;
  logic [CW-1:0] q_last;
  logic [CW-1:0] pos_m1;
  logic [FW-1:0] fill_m1;
  logic          is_open;
  logic          is_close;
  logic          done_early;

  // Narrow a code difference to an opener kind
  function automatic logic [brbc_pkg::OPEN_W-1:0] OPEN_W_TRUNC(
    input logic [brbc_pkg::CODE_W-1:0] v
  );
    return v[brbc_pkg::OPEN_W-1:0];
  endfunction

  assign in_stall  = (state_r != brbc_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_balanced = out_balanced_r;

  // Address arithmetic
  assign wr_pos    = CW'(in_position);
  assign wr_pos_m1 = wr_pos - CW'(1);
  assign q_first   = (in_range_begin == '0) ? CW'(1) : CW'(in_range_begin);
  assign q_last    = (CW'(in_range_end) > MAX_POS) ? MAX_POS : CW'(in_range_end);
  assign pos_m1    = pos_r - CW'(1);
  assign fill_m1   = fill_r - FW'(1);
  assign st_raddr  = pos_m1[AW-1:0];
  assign stk_raddr = fill_m1[AW-1:0];

  // Decode the fetched code
  assign is_open  = code_rd_r inside {[brbc_pkg::CODE_OPEN_P:brbc_pkg::CODE_OPEN_C]};
  assign is_close = code_rd_r inside {[brbc_pkg::CODE_CLOSE_P:brbc_pkg::CODE_CLOSE_C]};

  // Sequencer: next state, stack update and memory writes
  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    last_nxt         = last_r;
    fill_nxt         = fill_r;
    result_nxt       = result_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_balanced_nxt = out_balanced_r;
    st_we            = 1'b0;
    st_waddr         = wr_pos_m1[AW-1:0];
    st_wdata         = brbc_pkg::encode_symbol(in_symbol);
    stk_we           = 1'b0;
    stk_waddr        = fill_r[AW-1:0];
    stk_wdata        = OPEN_W_TRUNC(code_rd_r - brbc_pkg::CODE_OPEN_P);
    done_early       = 1'b0;

    case (state_r)
      brbc_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_kind == brbc_pkg::KIND_WRITE) begin
            st_we = (wr_pos != '0) && (wr_pos <= MAX_POS);
          end else begin
            fill_nxt = '0;
            pos_nxt  = q_first;
            last_nxt = q_last;
            if (q_first > q_last) begin
              result_nxt = 1'b1;
              state_nxt  = brbc_pkg::ST_DONE;
            end else begin
              state_nxt = brbc_pkg::ST_READ;
            end
          end
        end
      end

      // Store and stack reads are registered this cycle
      brbc_pkg::ST_READ: begin
        state_nxt = brbc_pkg::ST_EVAL;
      end

      brbc_pkg::ST_EVAL: begin
        if (is_open) begin
          if (fill_r == MAX_FILL) begin
            done_early = 1'b1;
          end else begin
            stk_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end
        end else if (is_close) begin
          if ((fill_r == '0) ||
              (top_rd_r != OPEN_W_TRUNC(code_rd_r - brbc_pkg::CODE_CLOSE_P))) begin
            done_early = 1'b1;
          end else begin
            fill_nxt = fill_m1;
          end
        end else begin
          done_early = 1'b1;
        end

        if (done_early) begin
          result_nxt = 1'b0;
          state_nxt  = brbc_pkg::ST_DONE;
        end else if (pos_r == last_r) begin
          result_nxt = (fill_nxt == '0);
          state_nxt  = brbc_pkg::ST_DONE;
        end else begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = brbc_pkg::ST_READ;
        end
      end

      // Hand the result to the output register once it is free
      brbc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_balanced_nxt = result_r;
          state_nxt        = brbc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = brbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brbc_pkg::ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r          <= pos_nxt;
    last_r         <= last_nxt;
    result_r       <= result_nxt;
    out_balanced_r <= out_balanced_nxt;
  end

  // Symbol store
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    code_rd_r <= store_mem[st_raddr];
  end

  // Opener stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    top_rd_r <= stack_mem[stk_raddr];
  end

endmodule
